// ----- sv/dbba_pkg.sv -----
`default_nettype none

package dbba_pkg;

  localparam int unsigned TRK_W          = 6;
  localparam int unsigned SEC_W          = 5;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned TOT_W          = 10;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned BIDX_W         = 2;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned ST_W           = 2;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned MAX_TRACKS_DEF = 40;
  localparam int unsigned BYTES_PER_TRK  = 3;

  localparam logic [TRK_W-1:0]  DIR_TRACK = 6'd18;
  localparam logic [TRK_W-1:0]  TIU_RESET = 6'd35;
  localparam logic [CNT_W-1:0]  SPT_MAX   = 5'd21;
  localparam logic [BIDX_W-1:0] LAST_BYTE = 2'd2;
  localparam logic [BIDX_W-1:0] BAD_BYTE  = 2'd3;
  localparam logic [0:0]        REG_TIU   = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD       = 3'd0,
    CMD_ALLOC_DATA = 3'd1,
    CMD_ALLOC_DIR  = 3'd2,
    CMD_FREE       = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_BAD_ADDR     = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  function automatic logic [CNT_W-1:0] zone_sectors(input logic [TRK_W-1:0] t);
    logic [CNT_W-1:0] n;
    if (t <= 6'd17) begin
      n = 5'd21;
    end else if (t <= 6'd24) begin
      n = 5'd19;
    end else if (t <= 6'd30) begin
      n = 5'd18;
    end else begin
      n = 5'd17;
    end
    return n;
  endfunction

  // bits of one bitmap byte that map to real sectors of the track
  function automatic logic [BYTE_W-1:0] zone_mask(input logic [TRK_W-1:0] t,
                                                  input logic [BIDX_W-1:0] b);
    logic [BYTE_W-1:0] m;
    if (b == BAD_BYTE) begin
      m = 8'h00;
    end else if (b == LAST_BYTE) begin
      case (zone_sectors(t))
        5'd21:   m = 8'h1F;
        5'd19:   m = 8'h07;
        5'd18:   m = 8'h03;
        default: m = 8'h01;
      endcase
    end else begin
      m = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [BYTE_W-1:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + {3'd0, x[i]};
    end
    return n;
  endfunction

  function automatic logic [2:0] low_bit(input logic [BYTE_W-1:0] x);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (x[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dbba_ram.sv -----
`default_nettype none

module dbba_ram #(
  parameter int unsigned WIDTH = dbba_pkg::BYTE_W,
  parameter int unsigned DEPTH = dbba_pkg::BYTES_PER_TRK * dbba_pkg::MAX_TRACKS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/disk_bam_block_allocator_top.sv -----
`default_nettype none

// Channel  Direction  Handshake                    Beat
// in       to block   in_valid_i / in_stall_o      command, track, sector, byte index, byte
// out      from block out_valid_o / out_stall_i    status, track, sector, free, counts
// config   to block   psel/penable/pwrite/pready   tracks_in_use at byte address 0
//
// One bitmap byte is read per cycle from the map RAM; a track takes three reads.
// Load, free and query read the three bytes of one track; a failed check goes straight to the result.
// Data allocation scans from track 1 up, skipping the directory track, until a track has a free sector.
// A config write taken while idle, with no beat accepted, recounts the total over the tracks in use.
// Reset marks every map byte unwritten, so all sectors read as used; no clearing pass.
// An item is taken only when the sequencer is idle; the result register frees the input side.

module disk_bam_block_allocator_top #(
  parameter int unsigned MAX_TRACKS = dbba_pkg::MAX_TRACKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dbba_pkg::CMD_W-1:0]     command_i,
  input  logic [dbba_pkg::TRK_W-1:0]     track_i,
  input  logic [dbba_pkg::SEC_W-1:0]     sector_i,
  input  logic [dbba_pkg::BIDX_W-1:0]    byte_index_i,
  input  logic [dbba_pkg::BYTE_W-1:0]    bitmap_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dbba_pkg::ST_W-1:0]      status_o,
  output logic [dbba_pkg::TRK_W-1:0]     out_track_o,
  output logic [dbba_pkg::SEC_W-1:0]     out_sector_o,
  output logic                           sector_is_free_o,
  output logic [dbba_pkg::CNT_W-1:0]     track_free_count_o,
  output logic [dbba_pkg::TOT_W-1:0]     total_free_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dbba_pkg::PADDR_W-1:0]   paddr,
  input  logic [dbba_pkg::PDATA_W-1:0]   pwdata,
  output logic [dbba_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import dbba_pkg::*;

  localparam int unsigned DEPTH = BYTES_PER_TRK * MAX_TRACKS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [TRK_W-1:0] MAX_T = TRK_W'(MAX_TRACKS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_e;

  function automatic logic [AW-1:0] trk_base(input logic [TRK_W-1:0] t);
    logic [TRK_W-1:0] tm1;
    logic [TRK_W+1:0] b3;
    tm1 = t - 6'd1;
    b3  = {1'b0, tm1, 1'b0} + {2'b00, tm1};
    return AW'(b3);
  endfunction

  state_e            state_q;
  logic [TRK_W-1:0]  tiu_q;
  logic [TOT_W-1:0]  total_q, sum_q;
  logic              tot_q, multi_q, iss_q, err_q;
  logic [TRK_W-1:0]  t_q, ptrk_q, trk_q;
  logic [BIDX_W-1:0] b_q, pb_q, fb_q, bidx_q;
  logic [AW-1:0]     addr_q;
  logic              pv_q, plast_q, found_q, rvld_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [BYTE_W-1:0] fdat_q, tdat_q, bval_q;
  logic [2:0]        fbit_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [SEC_W-1:0]  sec_q;
  logic [DEPTH-1:0]  vld_q;

  logic              ov_q, ofr_q;
  logic [ST_W-1:0]   ost_q;
  logic [TRK_W-1:0]  otrk_q;
  logic [SEC_W-1:0]  osec_q;
  logic [CNT_W-1:0]  ocnt_q;

  logic [TRK_W-1:0]  lim, new_lim, t1, nt, st_trk;
  logic              last_iss, in_acc, cfg_wr, trk_ok, addr_ok, in_go, in_err;
  logic [BYTE_W-1:0] rdata, rbyte, zm, smask, xs;
  logic [CNT_W-1:0]  c_full;
  logic              found_now;
  logic [BIDX_W-1:0] tgt_b;
  logic              re, we, fin_go, scan_done;
  logic [AW-1:0]     waddr;

  logic [ST_W-1:0]   res_st;
  logic [TRK_W-1:0]  res_trk, wtrk;
  logic [SEC_W-1:0]  res_sec;
  logic              res_fr, res_we, tbit;
  logic [CNT_W-1:0]  res_cnt, newc;
  logic [TOT_W-1:0]  res_tot;
  logic [BYTE_W-1:0] wdata, tzm;
  logic [BIDX_W-1:0] wb;

  assign lim     = (tiu_q > MAX_T) ? MAX_T : tiu_q;
  assign new_lim = (pwdata[TRK_W-1:0] > MAX_T) ? MAX_T : pwdata[TRK_W-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_TIU);
  assign prdata     = (paddr[2] == REG_TIU) ? {{(PDATA_W-TRK_W){1'b0}}, tiu_q} : '0;

  assign trk_ok  = (track_i >= 6'd1) && (track_i <= lim);
  assign addr_ok = trk_ok && (sector_i < zone_sectors(track_i));

  always_comb begin
    in_go  = 1'b0;
    in_err = 1'b1;
    st_trk = track_i;
    case (command_i)
      CMD_LOAD: begin
        in_go  = trk_ok && (byte_index_i != BAD_BYTE);
        in_err = !in_go;
      end
      CMD_ALLOC_DATA: begin
        in_go  = (lim != '0);
        in_err = 1'b0;
        st_trk = 6'd1;
      end
      CMD_ALLOC_DIR: begin
        in_go  = (lim >= DIR_TRACK);
        in_err = 1'b0;
        st_trk = DIR_TRACK;
      end
      CMD_FREE: begin
        in_go  = addr_ok && (track_i != DIR_TRACK);
        in_err = !in_go;
      end
      CMD_QUERY: begin
        in_go  = addr_ok;
        in_err = !in_go;
      end
      default: begin
        in_go  = 1'b0;
        in_err = 1'b1;
      end
    endcase
  end

  // issue side: next track, skipping the directory track on multi-track sweeps
  assign t1       = t_q + 6'd1;
  assign nt       = (multi_q && (t1 == DIR_TRACK)) ? t_q + 6'd2 : t1;
  assign last_iss = (b_q == LAST_BYTE) && (!multi_q || (nt > lim));
  assign re       = (state_q == S_SCAN) && iss_q;

  // process side: one byte per cycle, handled in the cycle after its read
  assign rbyte     = rvld_q ? rdata : 8'h00;
  assign zm        = zone_mask(ptrk_q, pb_q);
  assign smask     = ((cmd_q == CMD_ALLOC_DIR) && (pb_q == 2'd0)) ? 8'hFC : 8'hFF;
  assign xs        = rbyte & zm & smask;
  assign c_full    = cnt_q + CNT_W'(popcnt8(rbyte & zm));
  assign found_now = found_q || (xs != 8'h00);
  assign tgt_b     = (cmd_q == CMD_LOAD) ? bidx_q : sec_q[4:3];
  assign scan_done = pv_q && (pb_q == LAST_BYTE) &&
                     (plast_q || (!tot_q && multi_q && found_now));

  assign tzm  = zone_mask(trk_q, tgt_b);
  assign tbit = tdat_q[sec_q[2:0]];
  assign newc = cnt_q - CNT_W'(popcnt8(tdat_q & tzm)) + CNT_W'(popcnt8(bval_q & tzm));

  always_comb begin
    res_st  = ST_BAD_ADDR;
    res_trk = '0;
    res_sec = '0;
    res_fr  = 1'b0;
    res_cnt = '0;
    res_we  = 1'b0;
    res_tot = total_q;
    wdata   = bval_q;
    wtrk    = trk_q;
    wb      = tgt_b;
    if (!err_q) begin
      case (cmd_q)
        CMD_LOAD: begin
          res_st  = ST_OK;
          res_trk = trk_q;
          res_cnt = newc;
          res_we  = 1'b1;
          if (trk_q != DIR_TRACK) begin
            res_tot = total_q - TOT_W'(cnt_q) + TOT_W'(newc);
          end
        end
        CMD_ALLOC_DATA, CMD_ALLOC_DIR: begin
          if (found_q) begin
            res_st  = ST_OK;
            res_trk = ptrk_q;
            res_sec = {fb_q, fbit_q};
            res_cnt = cnt_q - 5'd1;
            res_we  = 1'b1;
            wdata   = fdat_q & ~(8'h01 << fbit_q);
            wtrk    = ptrk_q;
            wb      = fb_q;
            if (ptrk_q != DIR_TRACK) begin
              res_tot = total_q - 10'd1;
            end
          end else begin
            res_st = ST_NO_FREE;
          end
        end
        CMD_FREE: begin
          res_trk = trk_q;
          res_sec = sec_q;
          res_fr  = 1'b1;
          if (tbit) begin
            res_st  = ST_ALREADY_FREE;
            res_cnt = cnt_q;
          end else begin
            res_st  = ST_OK;
            res_cnt = cnt_q + 5'd1;
            res_we  = 1'b1;
            wdata   = tdat_q | (8'h01 << sec_q[2:0]);
            res_tot = total_q + 10'd1;
          end
        end
        CMD_QUERY: begin
          res_st  = ST_OK;
          res_trk = trk_q;
          res_sec = sec_q;
          res_fr  = tbit;
          res_cnt = cnt_q;
        end
        default: begin
          res_st = ST_BAD_ADDR;
        end
      endcase
    end
  end

  assign fin_go = (state_q == S_FIN) && (!ov_q || !out_stall_i);
  assign we     = fin_go && res_we;
  assign waddr  = trk_base(wtrk) + AW'(wb);

  dbba_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tiu_q   <= TIU_RESET;
      total_q <= '0;
      sum_q   <= '0;
      tot_q   <= 1'b0;
      multi_q <= 1'b0;
      iss_q   <= 1'b0;
      err_q   <= 1'b0;
      t_q     <= '0;
      ptrk_q  <= '0;
      trk_q   <= '0;
      b_q     <= '0;
      pb_q    <= '0;
      fb_q    <= '0;
      bidx_q  <= '0;
      addr_q  <= '0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      found_q <= 1'b0;
      rvld_q  <= 1'b0;
      cnt_q   <= '0;
      fdat_q  <= '0;
      tdat_q  <= '0;
      bval_q  <= '0;
      fbit_q  <= '0;
      cmd_q   <= '0;
      sec_q   <= '0;
      vld_q   <= '0;
      ov_q    <= 1'b0;
      ofr_q   <= 1'b0;
      ost_q   <= '0;
      otrk_q  <= '0;
      osec_q  <= '0;
      ocnt_q  <= '0;
    end else begin
      if (fin_go) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (cfg_wr) begin
        tiu_q <= pwdata[TRK_W-1:0];
      end
      if (re) begin
        rvld_q <= vld_q[addr_q];
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q   <= command_i;
            trk_q   <= track_i;
            sec_q   <= sector_i;
            bidx_q  <= byte_index_i;
            bval_q  <= bitmap_byte_i;
            err_q   <= in_err;
            tot_q   <= 1'b0;
            multi_q <= (command_i == CMD_ALLOC_DATA);
            found_q <= 1'b0;
            cnt_q   <= '0;
            pv_q    <= 1'b0;
            b_q     <= '0;
            t_q     <= st_trk;
            addr_q  <= trk_base(st_trk);
            iss_q   <= in_go;
            state_q <= in_go ? S_SCAN : S_FIN;
          end else if (cfg_wr) begin
            if (new_lim == '0) begin
              total_q <= '0;
            end else begin
              tot_q   <= 1'b1;
              multi_q <= 1'b1;
              found_q <= 1'b0;
              cnt_q   <= '0;
              sum_q   <= '0;
              pv_q    <= 1'b0;
              b_q     <= '0;
              t_q     <= 6'd1;
              addr_q  <= '0;
              iss_q   <= 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pv_q <= iss_q && !scan_done;
          if (scan_done || (iss_q && last_iss)) begin
            iss_q <= 1'b0;
          end
          if (iss_q && !scan_done) begin
            pb_q    <= b_q;
            ptrk_q  <= t_q;
            plast_q <= last_iss;
            if (b_q == LAST_BYTE) begin
              b_q    <= '0;
              t_q    <= nt;
              addr_q <= (nt != t1) ? addr_q + AW'(4) : addr_q + AW'(1);
            end else begin
              b_q    <= b_q + 2'd1;
              addr_q <= addr_q + AW'(1);
            end
          end
          if (pv_q) begin
            if (!found_q && (xs != 8'h00)) begin
              found_q <= 1'b1;
              fb_q    <= pb_q;
              fdat_q  <= rbyte;
              fbit_q  <= low_bit(xs);
            end
            if (pb_q == tgt_b) begin
              tdat_q <= rbyte;
            end
            if (pb_q == LAST_BYTE) begin
              if (tot_q) begin
                sum_q <= sum_q + TOT_W'(c_full);
                cnt_q <= '0;
                if (plast_q) begin
                  total_q <= sum_q + TOT_W'(c_full);
                  state_q <= S_IDLE;
                end
              end else if (plast_q || (multi_q && found_now)) begin
                cnt_q   <= c_full;
                state_q <= S_FIN;
              end else begin
                cnt_q <= '0;
              end
            end else begin
              cnt_q <= c_full;
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            ost_q   <= res_st;
            otrk_q  <= res_trk;
            osec_q  <= res_sec;
            ofr_q   <= res_fr;
            ocnt_q  <= res_cnt;
            total_q <= res_tot;
            if (res_we) begin
              vld_q[waddr] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = ov_q;
  assign status_o           = ost_q;
  assign out_track_o        = otrk_q;
  assign out_sector_o       = osec_q;
  assign sector_is_free_o   = ofr_q;
  assign track_free_count_o = ocnt_q;
  assign total_free_o       = total_q;

  // running track count never exceeds the largest zone
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SPT_MAX)
    else $error("track count out of range");

  // an allocation only ever clears a bit that was free
  a_alloc_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && !err_q && found_q &&
     ((cmd_q == CMD_ALLOC_DATA) || (cmd_q == CMD_ALLOC_DIR))) |-> fdat_q[fbit_q])
    else $error("allocated sector was not free");

  // an accepted beat always leaves the sequencer busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted beat dropped");

endmodule

`default_nettype wire
